// File: design/mtfs_pkg.sv
// ----------------------------------------------------------------------------
// mtfs_pkg
// Shared constants, codes and controller/datapath interface types for the
// monotonic table floor search.
// ----------------------------------------------------------------------------
package mtfs_pkg;

  localparam int IDX_W           = 10;
  localparam int VALUE_PORT_W    = 32;
  localparam int CFG_W           = 11;
  localparam int DEPTH_DEFAULT   = 1024;
  localparam int VALUE_W_DEFAULT = 32;

  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic STATUS_FOUND = 1'b0;
  localparam logic STATUS_OOR   = 1'b1;

  typedef enum logic [1:0] {
    RD_LO,
    RD_HI,
    RD_MID
  } rd_sel_t;

  typedef enum logic [2:0] {
    FIN_LO,
    FIN_HI,
    FIN_MID,
    FIN_BOUND,
    FIN_OOR
  } fin_sel_t;

  typedef struct packed {
    logic     write;
    logic     lookup;
    logic     cap_clo;
    logic     ends;
    logic     step;
    logic     finish;
    rd_sel_t  rd_sel;
    fin_sel_t fin_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic eq;
    logic gt;
    logic clo_eq;
    logic clo_gt;
    logic span_gt1;
  } dp_sts_t;

endpackage

// File: design/mtfs_ctrl.sv
// ----------------------------------------------------------------------------
// mtfs_ctrl
// Sequencer for loads and lookups: end checks, then one bisection probe per
// cycle until a match or two adjacent bounds are left.
// ----------------------------------------------------------------------------
module mtfs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              in_op,
  input  mtfs_pkg::dp_sts_t sts,
  output mtfs_pkg::dp_cmd_t cmd,
  output logic              busy
);
  import mtfs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_END_LO,
    S_END_HI,
    S_ENDS,
    S_PROBE
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;

  always_comb begin
    state_nxt   = state_r;
    busy_nxt    = busy_r;
    cmd         = '0;
    cmd.rd_sel  = RD_LO;
    cmd.fin_sel = FIN_LO;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_op == OP_LOAD) begin
            cmd.write = 1'b1;
          end else begin
            cmd.lookup = 1'b1;
            state_nxt  = S_END_LO;
            busy_nxt   = 1'b1;
          end
        end
      end
      S_END_LO: begin
        cmd.rd_sel = RD_LO;
        state_nxt  = S_END_HI;
      end
      S_END_HI: begin
        cmd.rd_sel  = RD_HI;
        cmd.cap_clo = 1'b1;
        state_nxt   = S_ENDS;
      end
      S_ENDS: begin
        if (sts.clo_eq) begin
          cmd.finish  = 1'b1;
          cmd.fin_sel = FIN_LO;
        end else if (sts.eq) begin
          cmd.finish  = 1'b1;
          cmd.fin_sel = FIN_HI;
        end else if (sts.clo_gt == sts.gt) begin
          cmd.finish  = 1'b1;
          cmd.fin_sel = FIN_OOR;
        end else begin
          cmd.ends = 1'b1;
          if (sts.span_gt1) begin
            cmd.rd_sel = RD_MID;
            state_nxt  = S_PROBE;
          end else begin
            cmd.finish  = 1'b1;
            cmd.fin_sel = FIN_BOUND;
          end
        end
        if (cmd.finish) begin
          state_nxt = S_IDLE;
          busy_nxt  = 1'b0;
        end
      end
      S_PROBE: begin
        if (sts.eq) begin
          cmd.finish  = 1'b1;
          cmd.fin_sel = FIN_MID;
        end else begin
          cmd.step = 1'b1;
          if (sts.span_gt1) begin
            cmd.rd_sel = RD_MID;
          end else begin
            cmd.finish  = 1'b1;
            cmd.fin_sel = FIN_BOUND;
          end
        end
        if (cmd.finish) begin
          state_nxt = S_IDLE;
          busy_nxt  = 1'b0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        busy_nxt  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
    end
  end

  assign busy = busy_r;

endmodule

// File: design/mtfs_dp.sv
// ----------------------------------------------------------------------------
// mtfs_dp
// Table memory, entry-count register, search bounds, comparator and result
// register.
// ----------------------------------------------------------------------------
module mtfs_dp #(
  parameter int TABLE_DEPTH = mtfs_pkg::DEPTH_DEFAULT,
  parameter int VALUE_WIDTH = mtfs_pkg::VALUE_W_DEFAULT
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  mtfs_pkg::dp_cmd_t                       cmd,
  output mtfs_pkg::dp_sts_t                       sts,
  input  logic        [mtfs_pkg::IDX_W-1:0]       in_entry_index,
  input  logic signed [mtfs_pkg::VALUE_PORT_W-1:0] in_entry_value,
  input  logic signed [mtfs_pkg::VALUE_PORT_W-1:0] in_query_value,
  input  logic                                    cfg_wr_en,
  input  logic        [mtfs_pkg::CFG_W-1:0]       cfg_wr_data,
  output logic                                    out_valid,
  output logic        [mtfs_pkg::IDX_W-1:0]       out_found_index,
  output logic                                    out_status
);
  import mtfs_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int NW = (CW > CFG_W) ? CW : CFG_W;
  localparam int LW = (AW > IDX_W) ? AW : IDX_W;
  localparam int XW = (VALUE_WIDTH > VALUE_PORT_W) ? VALUE_WIDTH : VALUE_PORT_W;

  logic signed [VALUE_WIDTH-1:0] mem [TABLE_DEPTH];
  logic signed [VALUE_WIDTH-1:0] rd_data_r;
  logic signed [VALUE_WIDTH-1:0] key_r;
  logic        [AW-1:0]          lo_r, hi_r, mid_r;
  logic                          clo_eq_r, clo_gt_r, desc_r;
  logic        [CFG_W-1:0]       cfg_r;
  logic                          out_valid_r;
  logic        [IDX_W-1:0]       out_index_r;
  logic                          out_status_r;

  logic signed [XW-1:0]          ext_e, ext_q;
  logic signed [VALUE_WIDTH-1:0] entry_w, query_w;
  logic        [LW-1:0]          idx_ext;
  logic                          wr_ok;
  logic        [NW-1:0]          cfg_ext, n_eff;
  logic        [AW-1:0]          hi_init;
  logic                          cmp_eq, cmp_gt;
  logic        [AW-1:0]          probe_lo, probe_hi, sel_lo, sel_hi;
  logic                          sel_desc;
  logic        [AW:0]            mid_sum;
  logic        [AW-1:0]          mid_nxt, span, rd_addr, found;
  logic        [LW-1:0]          found_ext;

  assign ext_e   = XW'(in_entry_value);
  assign ext_q   = XW'(in_query_value);
  assign entry_w = ext_e[VALUE_WIDTH-1:0];
  assign query_w = ext_q[VALUE_WIDTH-1:0];

  assign idx_ext = LW'(in_entry_index);
  assign wr_ok   = {1'b0, idx_ext} < (LW+1)'(TABLE_DEPTH);

  always_comb begin
    cfg_ext = NW'(cfg_r);
    if (cfg_ext == '0) begin
      n_eff = NW'(1);
    end else if (cfg_ext > NW'(TABLE_DEPTH)) begin
      n_eff = NW'(TABLE_DEPTH);
    end else begin
      n_eff = cfg_ext;
    end
  end
  assign hi_init = AW'(n_eff - NW'(1));

  assign cmp_eq = (rd_data_r == key_r);
  assign cmp_gt = (rd_data_r > key_r);

  always_comb begin
    probe_lo = lo_r;
    probe_hi = hi_r;
    if (cmp_gt == desc_r) begin
      probe_lo = mid_r;
    end else begin
      probe_hi = mid_r;
    end
  end

  assign sel_lo   = cmd.step ? probe_lo : lo_r;
  assign sel_hi   = cmd.step ? probe_hi : hi_r;
  assign sel_desc = cmd.ends ? clo_gt_r : desc_r;
  assign mid_sum  = {1'b0, sel_lo} + {1'b0, sel_hi};
  assign mid_nxt  = mid_sum[AW:1];
  assign span     = sel_hi - sel_lo;

  always_comb begin
    case (cmd.rd_sel)
      RD_LO:   rd_addr = lo_r;
      RD_HI:   rd_addr = hi_r;
      RD_MID:  rd_addr = mid_nxt;
      default: rd_addr = lo_r;
    endcase
  end

  always_comb begin
    case (cmd.fin_sel)
      FIN_LO:    found = lo_r;
      FIN_HI:    found = hi_r;
      FIN_MID:   found = mid_r;
      FIN_BOUND: found = sel_desc ? sel_hi : sel_lo;
      FIN_OOR:   found = '0;
      default:   found = '0;
    endcase
  end
  assign found_ext = LW'(found);

  always_ff @(posedge clk) begin
    if (cmd.write && wr_ok) begin
      mem[idx_ext[AW-1:0]] <= entry_w;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      key_r <= query_w;
      lo_r  <= '0;
      hi_r  <= hi_init;
    end
    if (cmd.cap_clo) begin
      clo_eq_r <= cmp_eq;
      clo_gt_r <= cmp_gt;
    end
    if (cmd.ends) begin
      desc_r <= clo_gt_r;
    end
    if (cmd.ends || cmd.step) begin
      mid_r <= mid_nxt;
    end
    if (cmd.step) begin
      lo_r <= probe_lo;
      hi_r <= probe_hi;
    end
    if (cmd.finish) begin
      out_index_r  <= found_ext[IDX_W-1:0];
      out_status_r <= (cmd.fin_sel == FIN_OOR) ? STATUS_OOR : STATUS_FOUND;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= CFG_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cfg_r <= cfg_wr_data;
      end
      out_valid_r <= cmd.finish;
    end
  end

  assign sts.eq       = cmp_eq;
  assign sts.gt       = cmp_gt;
  assign sts.clo_eq   = clo_eq_r;
  assign sts.clo_gt   = clo_gt_r;
  assign sts.span_gt1 = span > AW'(1);

  assign out_valid       = out_valid_r;
  assign out_found_index = out_index_r;
  assign out_status      = out_status_r;

endmodule

// File: design/monotonic_table_floor_search.sv
// ----------------------------------------------------------------------------
// monotonic_table_floor_search
// Monotonic table with entry loads and floor-index lookups by bisection.
// ----------------------------------------------------------------------------
// A load leaves busy low, so items may follow it back to back. A lookup
// holds busy high while it reads the two end entries, checks them and then
// makes its bisection probes (none when an end entry decides the result, at
// most about log2 of the entry count, 10 for 1024 entries); the result strobe
// out_valid rises in the cycle busy falls, and a new item may be started in
// that same cycle. The single-port table read gives one entry per cycle, for
// each end and each probe. Results cannot be held off and last exactly one
// cycle. Table entries are not cleared by reset and must be loaded before a
// lookup reaches them.
// ----------------------------------------------------------------------------
module monotonic_table_floor_search #(
  parameter int TABLE_DEPTH = mtfs_pkg::DEPTH_DEFAULT,
  parameter int VALUE_WIDTH = mtfs_pkg::VALUE_W_DEFAULT
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  output logic                                    busy,
  input  logic                                    in_op,
  input  logic        [mtfs_pkg::IDX_W-1:0]       in_entry_index,
  input  logic signed [mtfs_pkg::VALUE_PORT_W-1:0] in_entry_value,
  input  logic signed [mtfs_pkg::VALUE_PORT_W-1:0] in_query_value,
  output logic                                    out_valid,
  output logic        [mtfs_pkg::IDX_W-1:0]       out_found_index,
  output logic                                    out_status,
  input  logic                                    cfg_wr_en,
  input  logic        [mtfs_pkg::CFG_W-1:0]       cfg_wr_data
);
  import mtfs_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  mtfs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_op (in_op),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  mtfs_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_entry_index  (in_entry_index),
    .in_entry_value  (in_entry_value),
    .in_query_value  (in_query_value),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .out_valid       (out_valid),
    .out_found_index (out_found_index),
    .out_status      (out_status)
  );

endmodule

// File: design/mtfs_chk.sv
// ----------------------------------------------------------------------------
// mtfs_chk
// Port-level checks on busy, the result strobe and out-of-range results.
// ----------------------------------------------------------------------------
module mtfs_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       in_op,
  input logic                       out_valid,
  input logic [mtfs_pkg::IDX_W-1:0] out_found_index,
  input logic                       out_status
);
  import mtfs_pkg::*;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe high on two cycles in a row");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  a_oor_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STATUS_OOR) |-> out_found_index == '0)
    else $error("out-of-range result with non-zero index");

  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_op == OP_LOAD) |=> (!busy && !out_valid))
    else $error("load item raised busy or a result");

  a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_op == OP_LOOKUP) |=> busy)
    else $error("lookup item did not raise busy");

endmodule

bind monotonic_table_floor_search mtfs_chk u_mtfs_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_op           (in_op),
  .out_valid       (out_valid),
  .out_found_index (out_found_index),
  .out_status      (out_status)
);

// File: tb/sv/monotonic_table_floor_search_tb.sv
// ----------------------------------------------------------------------------
// monotonic_table_floor_search_tb
// Loads tables of varied shape and size, runs floor lookups against them and
// checks every result against a local copy of the table and search rules.
// ----------------------------------------------------------------------------
module monotonic_table_floor_search_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mtfs_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             status;
  } floor_result_t;

  typedef enum int {
    TBL_RISING,
    TBL_RISING_DUP,
    TBL_FALLING,
    TBL_FALLING_DUP,
    TBL_FLAT,
    TBL_SCRAMBLED
  } table_shape_t;

  localparam int SETTLE_CYCLES = 16;

  logic                           clk;
  logic                           rst_n;
  logic                           start;
  logic                           busy;
  logic                           in_op;
  logic        [IDX_W-1:0]        in_entry_index;
  logic signed [VALUE_PORT_W-1:0] in_entry_value;
  logic signed [VALUE_PORT_W-1:0] in_query_value;
  logic                           out_valid;
  logic        [IDX_W-1:0]        out_found_index;
  logic                           out_status;
  logic                           cfg_wr_en;
  logic        [CFG_W-1:0]        cfg_wr_data;

  logic signed [VALUE_PORT_W-1:0] table_mirror [DEPTH_DEFAULT];
  logic        [CFG_W-1:0]        entries_cfg = CFG_RESET;
  floor_result_t                  expected_floor [$];
  int                             send_idle_pct = 0;
  int                             items_sent = 0;
  int                             mismatch_count = 0;

  monotonic_table_floor_search dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_entry_index (in_entry_index),
    .in_entry_value (in_entry_value),
    .in_query_value (in_query_value),
    .out_valid      (out_valid),
    .out_found_index(out_found_index),
    .out_status     (out_status),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned active_entries();
    if (entries_cfg == 0) return 1;
    if (entries_cfg > DEPTH_DEFAULT) return DEPTH_DEFAULT;
    return entries_cfg;
  endfunction

  function automatic int compare_entry(input int unsigned pos,
                                       input logic signed [VALUE_PORT_W-1:0] q);
    if (table_mirror[pos] > q) return 1;
    if (table_mirror[pos] < q) return -1;
    return 0;
  endfunction

  function automatic floor_result_t predict_floor(input logic signed [VALUE_PORT_W-1:0] q);
    floor_result_t r;
    int unsigned   lo;
    int unsigned   hi;
    int unsigned   mid;
    int            c_lo;
    int            c_hi;
    int            c_mid;
    bit            falling;
    bit            hit;
    r.idx    = '0;
    r.status = STATUS_FOUND;
    lo       = 0;
    hi       = active_entries() - 1;
    c_lo     = compare_entry(lo, q);
    c_hi     = compare_entry(hi, q);
    if (c_lo * c_hi >= 0) begin
      if (c_lo == 0) r.idx = IDX_W'(lo);
      else if (c_hi == 0) r.idx = IDX_W'(hi);
      else r.status = STATUS_OOR;
    end else begin
      falling = (c_lo > 0);
      hit     = 1'b0;
      while (hi - lo > 1 && !hit) begin
        mid   = (lo + hi) >> 1;
        c_mid = compare_entry(mid, q);
        if (c_mid == 0) begin
          r.idx = IDX_W'(mid);
          hit   = 1'b1;
        end else if ((c_mid > 0) == falling) begin
          lo = mid;
        end else begin
          hi = mid;
        end
      end
      if (!hit) r.idx = IDX_W'(falling ? hi : lo);
    end
    return r;
  endfunction

  function automatic logic signed [VALUE_PORT_W-1:0] pick_query();
    int unsigned     span;
    int unsigned     k;
    longint          a;
    longint          b;
    longint          t;
    longint unsigned r;
    span = active_entries();
    k    = $urandom_range(span - 1);
    case ($urandom_range(7))
      0, 1: return table_mirror[k];
      2:    return table_mirror[k] + 1;
      3:    return table_mirror[k] - 1;
      4, 5: begin
        a = table_mirror[0];
        b = table_mirror[span - 1];
        if (a > b) begin
          t = a;
          a = b;
          b = t;
        end
        r = {$urandom, $urandom};
        return VALUE_PORT_W'(a + longint'(r % longint'(b - a + 1)));
      end
      6:       return $urandom;
      default: return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
    endcase
  endfunction

  task automatic drive_item(input logic op, input logic [IDX_W-1:0] index,
                            input logic signed [VALUE_PORT_W-1:0] entry,
                            input logic signed [VALUE_PORT_W-1:0] query);
    if ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    start          <= 1'b1;
    in_op          <= op;
    in_entry_index <= index;
    in_entry_value <= entry;
    in_query_value <= query;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (op == OP_LOAD) table_mirror[index] = entry;
    else expected_floor.push_back(predict_floor(query));
    items_sent++;
  endtask

  task automatic lookup(input logic signed [VALUE_PORT_W-1:0] query);
    drive_item(OP_LOOKUP, IDX_W'($urandom), $urandom, query);
  endtask

  task automatic set_entry_count(input logic [CFG_W-1:0] value);
    start <= 1'b0;
    while (expected_floor.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    entries_cfg = value;
    cfg_wr_en <= 1'b0;
  endtask

  task automatic load_table(input int unsigned count, input table_shape_t shape);
    int          vals [$];
    int unsigned order [$];
    int          base;
    base = $urandom;
    for (int unsigned i = 0; i < count; i++) begin
      case (shape)
        TBL_RISING_DUP, TBL_FALLING_DUP: vals.push_back(base + int'($urandom_range(count)));
        TBL_FLAT:                        vals.push_back(base);
        default:                         vals.push_back($urandom);
      endcase
      order.push_back(i);
    end
    if (shape == TBL_RISING || shape == TBL_RISING_DUP) vals.sort();
    if (shape == TBL_FALLING || shape == TBL_FALLING_DUP) vals.rsort();
    order.shuffle();
    foreach (order[j]) drive_item(OP_LOAD, IDX_W'(order[j]), vals[order[j]], $urandom);
  endtask

  task automatic test_reset_depth();
    load_table(DEPTH_DEFAULT, TBL_RISING);
    drive_item(OP_LOAD, '0, 32'sh8000_0000, $urandom);
    drive_item(OP_LOAD, IDX_W'(DEPTH_DEFAULT - 1), 32'sh7fff_ffff, $urandom);
    lookup(32'sh8000_0000);
    lookup(32'sh7fff_ffff);
    repeat (4) lookup(pick_query());
  endtask

  task automatic test_single_entry();
    set_entry_count('0);
    drive_item(OP_LOAD, '0, 32'sd1000, $urandom);
    lookup(32'sd1000);
    lookup(32'sd1001);
    lookup(32'sd999);
  endtask

  task automatic test_short_tables();
    set_entry_count(CFG_W'(2));
    drive_item(OP_LOAD, '0, 32'sd5, $urandom);
    drive_item(OP_LOAD, IDX_W'(1), -32'sd5, $urandom);
    lookup(32'sd0);
    lookup(-32'sd5);
    lookup(32'sd6);
    lookup(-32'sd6);
    set_entry_count(CFG_W'(5));
    load_table(5, TBL_FLAT);
    lookup(table_mirror[0]);
    lookup(table_mirror[0] + 1);
    set_entry_count(CFG_W'(9));
    load_table(9, TBL_FALLING);
    repeat (3) lookup(pick_query());
  endtask

  task automatic test_saturated_count();
    set_entry_count('1);
    repeat (3) lookup(pick_query());
    set_entry_count(CFG_W'(DEPTH_DEFAULT));
    lookup(pick_query());
  endtask

  task automatic test_random_traffic(input int idle_pct, input int item_goal);
    int          first;
    int unsigned pick;
    first         = items_sent;
    send_idle_pct = idle_pct;
    while (items_sent - first < item_goal) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        set_entry_count($urandom_range(1) ? CFG_W'(DEPTH_DEFAULT)
                                          : CFG_W'($urandom_range(DEPTH_DEFAULT + 1, 2047)));
      end else begin
        set_entry_count(pick < 10 ? CFG_W'($urandom_range(40, 160))
                                  : CFG_W'($urandom_range(24)));
        load_table(active_entries(),
                   $urandom_range(99) < 85 ? table_shape_t'($urandom_range(TBL_FLAT))
                                           : TBL_SCRAMBLED);
      end
      repeat ($urandom_range(8, 30)) begin
        if ($urandom_range(99) < 8) drive_item(OP_LOAD, IDX_W'($urandom), $urandom, $urandom);
        else lookup(pick_query());
      end
    end
  endtask

  always @(posedge clk) begin
    floor_result_t want;
    if (rst_n && out_valid) begin
      if (expected_floor.size() == 0) begin
        $error("unexpected result: found_index %0d status %0d", out_found_index, out_status);
        mismatch_count++;
      end else begin
        want = expected_floor.pop_front();
        if (out_found_index !== want.idx) begin
          $error("found_index: expected %0d, got %0d", want.idx, out_found_index);
          mismatch_count++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_op          <= OP_LOAD;
    in_entry_index <= '0;
    in_entry_value <= '0;
    in_query_value <= '0;
    cfg_wr_en      <= 1'b0;
    cfg_wr_data    <= CFG_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_depth();
    test_single_entry();
    test_short_tables();
    test_saturated_count();
    test_random_traffic(9, 10);
    test_random_traffic(86, 10);
    test_random_traffic(0, 10);

    start <= 1'b0;
    while (expected_floor.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
